// ===== hw/rtl/cfr_pkg.sv =====
// shared types, codes and constants of the command frame receiver
`timescale 1ns / 1ps

package cfr_pkg;

  // frame layout
  localparam int unsigned PAYLOAD_LIMIT = 50;
  localparam int unsigned KEEP_BYTES    = 18;
  localparam int unsigned ADDR_W        = $clog2(KEEP_BYTES);
  localparam int unsigned NUM_GAINS     = 9;
  localparam int unsigned ACK_BYTES     = 7;

  // header and function bytes
  localparam logic [7:0] HDR0_BYTE    = 8'hAA;
  localparam logic [7:0] HDR1_BYTE    = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT   = 8'hF1;
  localparam logic [7:0] FN_REQUEST   = 8'h02;
  localparam logic [7:0] FN_GAIN_LO   = 8'h10;
  localparam logic [7:0] FN_GAIN_HI   = 8'h11;
  localparam logic [7:0] FN_ACK_HI    = 8'h15;
  localparam logic [7:0] GROUP_OFFSET = 8'h0F;

  // request selector bytes
  localparam logic [7:0] SEL_PID_READ  = 8'h01;
  localparam logic [7:0] SEL_VERSION   = 8'hA0;
  localparam logic [7:0] SEL_PID_RESET = 8'hA1;

  // acknowledge frame bytes
  localparam logic [7:0] ACK_HEAD  = 8'hAA;
  localparam logic [7:0] ACK_TAG   = 8'hEF;
  localparam logic [7:0] ACK_LEN   = 8'h02;
  localparam logic [7:0] ACK_BASE  = 8'(ACK_HEAD + ACK_HEAD + ACK_TAG + ACK_LEN);

  // result kinds
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_REQ  = 2'd1;
  localparam logic [1:0] KIND_GAIN = 2'd2;

  // request codes
  localparam logic [1:0] REQ_PID_READ  = 2'd0;
  localparam logic [1:0] REQ_VERSION   = 2'd1;
  localparam logic [1:0] REQ_PID_RESET = 2'd2;

  // payload store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

  // payload store read port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  // finished frame handed to the emitter
  typedef struct packed {
    logic       start;
    logic [7:0] fn;
    logic [7:0] sum;
  } job_t;

  // one result item
  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        tx_byte;
    logic [1:0]        req;
    logic [1:0]        group;
    logic [3:0]        index;
    logic signed [15:0] value;
    logic              last;
  } result_t;

endpackage

// ===== hw/rtl/checksummed_command_frame_receiver.sv =====
// Checksummed command frame receiver, top level.
// Input channel: one received serial byte per item (rx_byte_i) under
// in_valid_i / in_stall_o. Output channel: result items under
// out_valid_o / out_stall_i, one field per port, last_result_o marking the
// final item caused by one input byte.
// The parser hunts for header AA AF, a function byte, a length, the payload
// and a sum checksum. Payload bytes 0 to 17 are kept in an 18-entry memory
// with registered read; unwritten entries read as zero.
// A byte that finishes no frame leaves in_stall_o low.
// A matching checksum byte of a request, gain or acknowledge frame starts the
// result sequencer and holds the input stalled until its last item is in
// the output register (an unknown request selector yields no item): a request
// event reads its selector byte, an acknowledge frame gives one item per byte,
// and a gain frame nine gain words (two memory reads each) before its
// acknowledge; the single memory read port sets the pace.
// A stalled output holds its item; the sequencer waits with the next one
// and the input may take a new byte while the final item still waits.
// Reset clears the parser, the sequencer state, the output valid bit and the
// payload valid bits at once; no clearing pass is needed.
`timescale 1ns / 1ps

module checksummed_command_frame_receiver #(
  parameter int unsigned PayloadLimit = cfr_pkg::PAYLOAD_LIMIT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         result_kind_o,
  output logic [7:0]         tx_byte_o,
  output logic [1:0]         request_code_o,
  output logic [1:0]         gain_group_o,
  output logic [3:0]         gain_index_o,
  output logic signed [15:0] gain_value_o,
  output logic               last_result_o
);
  import cfr_pkg::*;

  logic    accept;
  logic    busy;
  wr_req_t wr;
  rd_req_t rd;
  job_t    job;
  result_t res;
  logic [7:0] rd_data;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = busy;

  // byte parser
  cfr_parser #(
    .PayloadLimit(PayloadLimit)
  ) u_parser (
    .clk_i,
    .rst_ni,
    .accept_i (accept),
    .rx_byte_i,
    .wr_o     (wr),
    .job_o    (job)
  );

  // payload memory
  cfr_store u_store (
    .clk_i,
    .rst_ni,
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  // result sequencer and output register
  cfr_emitter u_emitter (
    .clk_i,
    .rst_ni,
    .job_i       (job),
    .rd_data_i   (rd_data),
    .rd_o        (rd),
    .busy_o      (busy),
    .out_valid_o,
    .out_stall_i,
    .out_o       (res)
  );

  assign result_kind_o  = res.kind;
  assign tx_byte_o      = res.tx_byte;
  assign request_code_o = res.req;
  assign gain_group_o   = res.group;
  assign gain_index_o   = res.index;
  assign gain_value_o   = res.value;
  assign last_result_o  = res.last;

  // a waiting item that is not the last keeps the input stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_result_o |-> in_stall_o)
    else $error("input released before the final result item");

  // the sequencer only starts after an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("sequencer started without an input item");

  // gain words are never final and stay within the nine positions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_GAIN) |-> !last_result_o && (gain_index_o <= 4'd8))
    else $error("malformed gain result item");

endmodule

// ===== hw/rtl/cfr_store.sv =====
// payload byte memory with per-entry valid bits and registered read
`timescale 1ns / 1ps

module cfr_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfr_pkg::wr_req_t wr_i,
  input  cfr_pkg::rd_req_t rd_i,
  output logic [7:0]       rd_data_o
);
  import cfr_pkg::*;

  logic [7:0]            mem_q [KEEP_BYTES];
  logic [KEEP_BYTES-1:0] vld_q;
  logic [7:0]            rd_data_q;
  logic                  rd_vld_q;

  // memory array write
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // valid bits, cleared at reset so unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
      rd_vld_q  <= vld_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : 8'h00;

endmodule

// ===== hw/rtl/cfr_parser.sv =====
// frame parser: header hunt, length, payload capture and checksum
`timescale 1ns / 1ps

module cfr_parser #(
  parameter int unsigned PayloadLimit = cfr_pkg::PAYLOAD_LIMIT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  output cfr_pkg::wr_req_t wr_o,
  output cfr_pkg::job_t    job_o
);
  import cfr_pkg::*;

  localparam int unsigned CountW = $clog2(PayloadLimit);

  typedef enum logic [5:0] {
    PH_HDR0 = 6'b000001,
    PH_HDR1 = 6'b000010,
    PH_FUNC = 6'b000100,
    PH_LEN  = 6'b001000,
    PH_PAY  = 6'b010000,
    PH_CHK  = 6'b100000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        fn_q, fn_d;
  logic [7:0]        sum_q, sum_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              keep;
  logic              frame_ok;

  assign keep = cnt_q < CountW'(KEEP_BYTES);

  // frames that start the result sequencer
  assign frame_ok = (rx_byte_i == sum_q) &&
                    ((fn_q == FN_REQUEST) || ((fn_q >= FN_GAIN_LO) && (fn_q <= FN_ACK_HI)));

  // next-state logic for one byte
  always_comb begin
    phase_d = phase_q;
    fn_d    = fn_q;
    sum_d   = sum_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    wr_o    = '{en: 1'b0, addr: cnt_q[ADDR_W-1:0], data: rx_byte_i};
    job_o   = '{start: 1'b0, fn: fn_q, sum: sum_q};
    if (accept_i) begin
      phase_d = PH_HDR0;
      case (phase_q)
        PH_HDR0: begin
          if (rx_byte_i == HDR0_BYTE) begin
            phase_d = PH_HDR1;
            sum_d   = rx_byte_i;
          end
        end
        PH_HDR1: begin
          if (rx_byte_i == HDR1_BYTE) begin
            phase_d = PH_FUNC;
            sum_d   = sum_q + rx_byte_i;
          end
        end
        PH_FUNC: begin
          if (rx_byte_i < FUNC_LIMIT) begin
            phase_d = PH_LEN;
            fn_d    = rx_byte_i;
            sum_d   = sum_q + rx_byte_i;
          end
        end
        PH_LEN: begin
          if (rx_byte_i < 8'(PayloadLimit)) begin
            phase_d = PH_PAY;
            rem_d   = rx_byte_i[CountW-1:0];
            cnt_d   = '0;
            sum_d   = sum_q + rx_byte_i;
          end
        end
        PH_PAY: begin
          // a zero length drops this byte and restarts the hunt
          if (rem_q != '0) begin
            rem_d   = rem_q - 1'b1;
            cnt_d   = cnt_q + 1'b1;
            sum_d   = sum_q + rx_byte_i;
            wr_o.en = keep;
            phase_d = (rem_q == CountW'(1)) ? PH_CHK : PH_PAY;
          end
        end
        PH_CHK: begin
          // checksum byte lands in the store as well
          wr_o.en     = keep;
          job_o.start = frame_ok;
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      fn_q    <= '0;
      sum_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      fn_q    <= fn_d;
      sum_q   <= sum_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/cfr_emitter.sv =====
// result sequencer: reads the payload store and drives the output register
`timescale 1ns / 1ps

module cfr_emitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfr_pkg::job_t     job_i,
  input  logic [7:0]        rd_data_i,
  output cfr_pkg::rd_req_t  rd_o,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cfr_pkg::result_t  out_o
);
  import cfr_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_REQ  = 8'b00000010,
    ST_REQW = 8'b00000100,
    ST_HI   = 8'b00001000,
    ST_LO   = 8'b00010000,
    ST_WORD = 8'b00100000,
    ST_ACK  = 8'b01000000,
    ST_PUSH = 8'b10000000
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] fn_q, fn_d;
  logic [7:0] sum_q, sum_d;
  logic [3:0] idx_q, idx_d;
  logic [7:0] hi_q, hi_d;
  result_t    res_q, res_d;
  logic       out_valid_q, out_valid_d;
  result_t    out_q, out_d;
  logic       slot_free;
  logic [7:0] ack_byte;
  logic [1:0] group;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign group     = 2'(fn_q - GROUP_OFFSET);

  // acknowledge frame byte at the current position
  always_comb begin
    case (idx_q)
      4'd0, 4'd1: ack_byte = ACK_HEAD;
      4'd2:       ack_byte = ACK_TAG;
      4'd3:       ack_byte = ACK_LEN;
      4'd4:       ack_byte = fn_q;
      4'd5:       ack_byte = sum_q;
      default:    ack_byte = ACK_BASE + fn_q + sum_q;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    fn_d        = fn_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    hi_d        = hi_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_o        = '{en: 1'b0, addr: '0};
    case (state_q)
      ST_IDLE: begin
        if (job_i.start) begin
          fn_d  = job_i.fn;
          sum_d = job_i.sum;
          idx_d = '0;
          if (job_i.fn == FN_REQUEST) begin
            state_d = ST_REQ;
          end else if (job_i.fn <= FN_GAIN_HI) begin
            state_d = ST_HI;
          end else begin
            state_d = ST_ACK;
          end
        end
      end
      ST_REQ: begin
        rd_o    = '{en: 1'b1, addr: '0};
        state_d = ST_REQW;
      end
      ST_REQW: begin
        res_d      = '0;
        res_d.kind = KIND_REQ;
        res_d.last = 1'b1;
        state_d    = ST_PUSH;
        case (rd_data_i)
          SEL_PID_READ:  res_d.req = REQ_PID_READ;
          SEL_VERSION:   res_d.req = REQ_VERSION;
          SEL_PID_RESET: res_d.req = REQ_PID_RESET;
          default:       state_d   = ST_IDLE;
        endcase
      end
      ST_HI: begin
        rd_o    = '{en: 1'b1, addr: ADDR_W'({idx_q, 1'b0})};
        state_d = ST_LO;
      end
      ST_LO: begin
        rd_o    = '{en: 1'b1, addr: ADDR_W'({idx_q, 1'b1})};
        hi_d    = rd_data_i;
        state_d = ST_WORD;
      end
      ST_WORD: begin
        res_d       = '0;
        res_d.kind  = KIND_GAIN;
        res_d.group = group;
        res_d.index = idx_q;
        res_d.value = {hi_q, rd_data_i};
        state_d     = ST_PUSH;
      end
      ST_ACK: begin
        res_d         = '0;
        res_d.kind    = KIND_ACK;
        res_d.tx_byte = ack_byte;
        res_d.last    = (idx_q == 4'(ACK_BYTES - 1));
        state_d       = ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          if (res_q.last) begin
            state_d = ST_IDLE;
          end else if ((res_q.kind == KIND_GAIN) && (idx_q == 4'(NUM_GAINS - 1))) begin
            idx_d   = '0;
            state_d = ST_ACK;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = (res_q.kind == KIND_GAIN) ? ST_HI : ST_ACK;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fn_q  <= fn_d;
    sum_q <= sum_d;
    hi_q  <= hi_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
